FILE: design/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Shared widths and the control word for the sorting cells of the
// sliding window median filter.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int unsigned IN_BITS  = 16;
  localparam int unsigned OUT_BITS = 16;

  // control handed from the sequencer to every cell of the sort chain
  typedef struct packed {
    logic load;   // take a fresh copy of the window
    logic step;   // do one compare-exchange pass
    logic phase;  // which pairing the pass uses: even or odd
  } sort_ctrl_t;

endpackage

FILE: design/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell
// One cell of an odd-even transposition sort chain. It holds one sample and
// exchanges with its left or right neighbor depending on the pass phase.
// ----------------------------------------------------------------------------
module swm_cell #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned WINDOW      = 8,
  parameter int unsigned IDX         = 0
) (
  input  logic                   clk_i,
  input  swm_pkg::sort_ctrl_t    ctrl_i,
  input  logic [SAMPLE_BITS-1:0] load_val_i,
  input  logic [SAMPLE_BITS-1:0] left_i,
  input  logic [SAMPLE_BITS-1:0] right_i,
  output logic [SAMPLE_BITS-1:0] value_o
);
  import swm_pkg::*;

  localparam bit HasLeft  = (IDX > 0);
  localparam bit HasRight = (IDX + 1 < WINDOW);
  localparam bit OddIdx   = ((IDX % 2) == 1);

  logic [SAMPLE_BITS-1:0] value_q, value_d;
  logic                   pair_right, pair_left;

  // a cell pairs with its right neighbor when the phase matches its parity
  assign pair_right = HasRight && (ctrl_i.phase == OddIdx);
  assign pair_left  = HasLeft  && (ctrl_i.phase != OddIdx);

  always_comb begin
    value_d = value_q;
    if (ctrl_i.load) begin
      value_d = load_val_i;
    end else if (ctrl_i.step) begin
      if (pair_right && (right_i < value_q)) begin
        value_d = right_i;
      end else if (pair_left && (left_i > value_q)) begin
        value_d = left_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

FILE: design/swm_sort_chain.sv
// ----------------------------------------------------------------------------
// swm_sort_chain
// Row of sort cells. After a load and WINDOW passes the row is ascending;
// the two middle cells are brought out.
// ----------------------------------------------------------------------------
module swm_sort_chain #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned WINDOW      = 8
) (
  input  logic                               clk_i,
  input  swm_pkg::sort_ctrl_t                ctrl_i,
  input  logic [WINDOW-1:0][SAMPLE_BITS-1:0] load_vals_i,
  output logic [SAMPLE_BITS-1:0]             mid_lo_o,
  output logic [SAMPLE_BITS-1:0]             mid_hi_o
);
  import swm_pkg::*;

  localparam int unsigned MidLo = (WINDOW - 1) / 2;
  localparam int unsigned MidHi = WINDOW / 2;

  logic [SAMPLE_BITS-1:0] vals [WINDOW];

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    logic [SAMPLE_BITS-1:0] left_val, right_val;

    if (i > 0) begin : g_left
      assign left_val = vals[i-1];
    end else begin : g_no_left
      assign left_val = '0;
    end

    if (i + 1 < WINDOW) begin : g_right
      assign right_val = vals[i+1];
    end else begin : g_no_right
      assign right_val = '0;
    end

    swm_cell #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .WINDOW     (WINDOW),
      .IDX        (i)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl_i),
      .load_val_i(load_vals_i[i]),
      .left_i    (left_val),
      .right_i   (right_val),
      .value_o   (vals[i])
    );
  end

  assign mid_lo_o = vals[MidLo];
  assign mid_hi_o = vals[MidHi];

endmodule

FILE: design/sliding_window_median.sv
// ----------------------------------------------------------------------------
// sliding_window_median
// Median of the last WINDOW distance samples, taken as the floor mean of the
// two middle values of the sorted window.
//
//   channel   direction  payload              handshake
//   distance  in         distance_sample_i    distance_valid_i / distance_stall_o
//   median    out        median_distance_o    median_valid_o / median_stall_i
//
// A word is taken when the block is idle; the window shifts and a copy goes
// into the sort chain in that same cycle. WINDOW compare-exchange passes of
// the chain follow, then the finishing state loads the output register once
// the output is free. Reset clears the window to zero, so early medians
// count the empty slots as zeros. A result waiting on median_stall_i does
// not block the next word; only a second finished result waits until the
// first is taken.
// ----------------------------------------------------------------------------
module sliding_window_median #(
  parameter int unsigned WINDOW      = 8,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [swm_pkg::IN_BITS-1:0]  distance_sample_i,
  input  logic                         distance_valid_i,
  output logic                         distance_stall_o,
  output logic [swm_pkg::OUT_BITS-1:0] median_distance_o,
  output logic                         median_valid_o,
  input  logic                         median_stall_i
);
  import swm_pkg::*;

  localparam int unsigned CntW = $clog2(WINDOW);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SORT = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]                         state_q, state_d;
  logic [CntW-1:0]                    pass_q, pass_d;
  logic [WINDOW-1:0][SAMPLE_BITS-1:0] win_q, win_d;
  logic                               out_valid_q, out_valid_d;
  logic [OUT_BITS-1:0]                out_q, out_d;

  logic                               in_accept;
  logic                               out_free;
  sort_ctrl_t                         ctrl;
  logic [SAMPLE_BITS-1:0]             mid_lo, mid_hi;
  logic [SAMPLE_BITS:0]               mid_sum;
  logic [SAMPLE_BITS-1:0]             mid_half;
  logic [SAMPLE_BITS+IN_BITS-1:0]     in_ext;
  logic [SAMPLE_BITS+OUT_BITS-1:0]    out_ext;

  assign in_accept = distance_valid_i && !distance_stall_o;
  assign out_free  = !out_valid_q || !median_stall_i;

  assign in_ext  = {{SAMPLE_BITS{1'b0}}, distance_sample_i};
  assign mid_sum = {1'b0, mid_lo} + {1'b0, mid_hi};
  assign mid_half = mid_sum[SAMPLE_BITS:1];
  assign out_ext = {{OUT_BITS{1'b0}}, mid_half};

  // window as a shift line: entry 0 newest, the oldest falls off the end
  always_comb begin
    win_d = win_q;
    if (in_accept) begin
      win_d[0] = in_ext[SAMPLE_BITS-1:0];
      for (int i = 1; i < WINDOW; i++) begin
        win_d[i] = win_q[i-1];
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    pass_d      = pass_q;
    out_valid_d = out_valid_q && median_stall_i;
    out_d       = out_q;
    ctrl.load   = 1'b0;
    ctrl.step   = 1'b0;
    ctrl.phase  = pass_q[0];
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          ctrl.load = 1'b1;
          pass_d    = '0;
          state_d   = S_SORT;
        end
      end
      S_SORT: begin
        ctrl.step = 1'b1;
        pass_d    = pass_q + 1'b1;
        if (pass_q == CntW'(WINDOW - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_d       = out_ext[OUT_BITS-1:0];
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  swm_sort_chain #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .WINDOW     (WINDOW)
  ) u_chain (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .load_vals_i(win_d),
    .mid_lo_o   (mid_lo),
    .mid_hi_o   (mid_hi)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pass_q      <= '0;
      win_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      win_q       <= win_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign distance_stall_o  = (state_q != S_IDLE);
  assign median_valid_o    = out_valid_q;
  assign median_distance_o = out_q;

  // an accepted word always starts a sort run
  a_accept_sorts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == S_SORT && pass_q == '0))
    else $error("accepted word did not start sorting");

  // the pass counter never runs past the last pass
  a_pass_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SORT) |-> (pass_q <= CntW'(WINDOW - 1)))
    else $error("sort pass count out of range");

  // once sorted, the middle cells are in order and the mean lies between them
  a_mid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> (mid_lo <= mid_hi && mid_half >= mid_lo && mid_half <= mid_hi))
    else $error("sort chain middle values out of order");

  // a new result only appears out of the finishing state
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_DONE))
    else $error("result valid without a finished sort");

endmodule
